// File: hw/rtl/utf8v_pkg.sv
`timescale 1ns / 1ps
// utf8v_pkg: types, byte masks and the byte classifier for the utf-8 validator
// no dependencies; used by utf8v_check and the top level

package utf8v_pkg;

    // byte masks and codes
    localparam logic [7:0] MASK_LEAD4 = 8'd248;
    localparam logic [7:0] CODE_LEAD4 = 8'd240;
    localparam logic [7:0] MASK_LEAD3 = 8'd240;
    localparam logic [7:0] CODE_LEAD3 = 8'd224;
    localparam logic [7:0] MASK_LEAD2 = 8'd224;
    localparam logic [7:0] CODE_LEAD2 = 8'd192;
    localparam logic [7:0] MASK_CONT  = 8'd192;
    localparam logic [7:0] CODE_CONT  = 8'd128;
    localparam logic [7:0] HIGH_BIT   = 8'd128;

    localparam int OWED_W = 2;

    typedef logic [OWED_W-1:0] t_owed;

    typedef enum logic [2:0] {
        KIND_ASCII,
        KIND_CONT,
        KIND_LEAD2,
        KIND_LEAD3,
        KIND_LEAD4,
        KIND_BAD
    } t_byte_kind;

    // one byte handed from the input register to the checker
    typedef struct packed {
        logic       step;
        logic       last;
        logic [7:0] data;
    } t_step;

    // checker state, also shown to the top level
    typedef struct packed {
        t_owed owed;
        logic  err;
    } t_chk_state;

    function automatic t_byte_kind classify(input logic [7:0] b);
        t_byte_kind k;
        if ((b & HIGH_BIT) == 8'd0) begin
            k = KIND_ASCII;
        end else if ((b & MASK_CONT) == CODE_CONT) begin
            k = KIND_CONT;
        end else if ((b & MASK_LEAD2) == CODE_LEAD2) begin
            k = KIND_LEAD2;
        end else if ((b & MASK_LEAD3) == CODE_LEAD3) begin
            k = KIND_LEAD3;
        end else if ((b & MASK_LEAD4) == CODE_LEAD4) begin
            k = KIND_LEAD4;
        end else begin
            k = KIND_BAD;
        end
        return k;
    endfunction

endpackage

// File: hw/rtl/utf8v_if.sv
`timescale 1ns / 1ps
// utf8v_byte_if and utf8v_res_if: valid/ready channels of the validator
// depends on nothing but plain logic types

interface utf8v_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface utf8v_res_if;
    logic valid;
    logic ready;
    logic valid_res;

    modport source (output valid, output valid_res, input ready);
    modport sink   (input valid, input valid_res, output ready);
endinterface

// File: hw/rtl/utf8v_check.sv
`timescale 1ns / 1ps
// utf8v_check: owed count and sticky error state, next-state logic and verdict
// depends on utf8v_pkg

module utf8v_check (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  utf8v_pkg::t_step      i_step,
    output logic                  o_verdict,
    output utf8v_pkg::t_chk_state o_state
);

    utf8v_pkg::t_owed      r_owed, n_owed;
    logic                  r_err, n_err;
    utf8v_pkg::t_owed      upd_owed;
    logic                  upd_err;
    utf8v_pkg::t_byte_kind kind;

    assign kind = utf8v_pkg::classify(i_step.data);

    // state after this byte, before the end-of-string clear
    always_comb begin
        upd_owed = r_owed;
        upd_err  = r_err;
        if (!r_err) begin
            if (r_owed != '0) begin
                if (kind == utf8v_pkg::KIND_CONT) begin
                    upd_owed = r_owed - utf8v_pkg::t_owed'(1);
                end else begin
                    upd_err = 1'b1;
                end
            end else begin
                case (kind)
                    utf8v_pkg::KIND_ASCII: upd_owed = r_owed;
                    utf8v_pkg::KIND_LEAD2: upd_owed = utf8v_pkg::t_owed'(1);
                    utf8v_pkg::KIND_LEAD3: upd_owed = utf8v_pkg::t_owed'(2);
                    utf8v_pkg::KIND_LEAD4: upd_owed = utf8v_pkg::t_owed'(3);
                    default:               upd_err  = 1'b1;
                endcase
            end
        end
    end

    assign o_verdict = !upd_err && (upd_owed == '0);

    always_comb begin
        n_owed = r_owed;
        n_err  = r_err;
        if (i_step.step) begin
            if (i_step.last) begin
                n_owed = '0;
                n_err  = 1'b0;
            end else begin
                n_owed = upd_owed;
                n_err  = upd_err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owed <= '0;
            r_err  <= 1'b0;
        end else begin
            r_owed <= n_owed;
            r_err  <= n_err;
        end
    end

    assign o_state.owed = r_owed;
    assign o_state.err  = r_err;

    // string end leaves a clean state for the next string
    a_clear_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step.step && i_step.last |=> r_owed == '0 && !r_err)
        else $error("state not cleared after last byte");

    // error is sticky inside a string
    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err && !(i_step.step && i_step.last) |=> r_err)
        else $error("error flag dropped inside a string");

    // a passing verdict never follows a seen error
    a_err_fails: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err |-> !o_verdict)
        else $error("valid verdict after error");

endmodule

// File: hw/rtl/utf8_stream_validator.sv
`timescale 1ns / 1ps
// utf8_stream_validator: top level, input register, checker and result register
// depends on utf8v_pkg, utf8v_if.sv and utf8v_check
//
// usage:
//  - i_byte carries one string byte per item, last_byte marks the final byte
//  - o_res carries one verdict item per string, valid_res = 1 when the string
//    is well-formed utf-8 (overlongs, surrogates, > U+10FFFF not checked)
//  - an empty string has no bytes and must be handled outside this block
//  - throughput: one byte per cycle while o_res is not stalled, set by the single
//    registered pass from input register through checker to result register
//  - a verdict reaches o_res by way of the input register and then the result
//    register; a stalled o_res can hold the final byte in the input register
//  - a stalled o_res holds its verdict; non-final bytes keep flowing until a
//    second verdict would need the busy result register, then i_byte.ready
//    drops until o_res is taken
//  - reset (i_rst_n low, synchronous) empties both registers and clears the
//    owed count and the error flag; the first byte after reset starts a string

module utf8_stream_validator (
    input  logic              i_clk,
    input  logic              i_rst_n,
    utf8v_byte_if.sink        i_byte,
    utf8v_res_if.source       o_res
);

    // input register
    logic       r_s1_valid, n_s1_valid;
    logic [7:0] r_s1_data;
    logic       r_s1_last;

    // result register
    logic       r_out_valid, n_out_valid;
    logic       r_out_res;

    logic                  out_free;
    logic                  s1_fire;
    logic                  in_fire;
    logic                  verdict;
    utf8v_pkg::t_step      chk_step;
    utf8v_pkg::t_chk_state chk_state;

    // result slot can take a verdict this cycle
    assign out_free = !r_out_valid || o_res.ready;
    // non-final bytes never need the result slot
    assign s1_fire  = r_s1_valid && (!r_s1_last || out_free);
    assign i_byte.ready = !r_s1_valid || s1_fire;
    assign in_fire  = i_byte.valid && i_byte.ready;

    assign n_s1_valid  = in_fire || (r_s1_valid && !s1_fire);
    assign n_out_valid = (s1_fire && r_s1_last) || (r_out_valid && !o_res.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_data <= i_byte.data_byte;
            r_s1_last <= i_byte.last_byte;
        end
        if (s1_fire && r_s1_last) begin
            r_out_res <= verdict;
        end
    end

    assign chk_step.step = s1_fire;
    assign chk_step.last = r_s1_last;
    assign chk_step.data = r_s1_data;

    utf8v_check u_check (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (chk_step),
        .o_verdict (verdict),
        .o_state   (chk_state)
    );

    assign o_res.valid     = r_out_valid;
    assign o_res.valid_res = r_out_res;

    // a final byte that leaves the input register always lands a verdict
    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_fire && r_s1_last |=> r_out_valid)
        else $error("final byte produced no verdict");

    // a passing verdict only when the checker had no error at that byte
    a_pass_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_fire && r_s1_last && verdict |-> !chk_state.err)
        else $error("passing verdict with error set");

    // a held final byte waits only on a stalled result slot
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !s1_fire |-> r_s1_last && r_out_valid && !o_res.ready)
        else $error("input register stalled without cause");

endmodule
